[rtl/vga_pkg.sv]
// Shared types, constants and helpers for the visibility gain apply block.
// Used by every RTL module of the block except vga_ram; depends on nothing.
`default_nettype none

package vga_pkg;

    // Field widths fixed by the item formats
    localparam int ELEM_W           = 11;
    localparam int CFG_W            = 12;
    localparam int IDX_MAX_W        = 12;
    localparam int MAX_ELEMENTS_DEF = 2048;
    localparam int Q_DEPTH          = 2;
    localparam int RAM_W            = 64;

    localparam logic [CFG_W-1:0]  ELEMS_RESET = 12'd2048;
    localparam logic signed [15:0] GAIN_ONE   = 16'sd8192;

    // Request codes
    typedef enum logic [1:0] {
        REQ_LOAD    = 2'd0,
        REQ_PRODUCT = 2'd1,
        REQ_FRAME   = 2'd2,
        REQ_NONE    = 2'd3
    } t_req;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [ELEM_W-1:0]  element;
        logic signed [15:0] new_gain_re;
        logic signed [15:0] new_gain_im;
        logic signed [15:0] old_gain_re;
        logic signed [15:0] old_gain_im;
        logic [15:0]        gain_wt;
        logic               blend_on;
        logic [15:0]        blend_coef;
        logic signed [31:0] vis_re;
        logic signed [31:0] vis_im;
        logic [31:0]        vis_weight;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] out_re;
        logic signed [31:0] out_im;
        logic [31:0]        scaled_wt;
        logic [ELEM_W-1:0]  row;
        logic [ELEM_W-1:0]  col;
        logic               last;
    } t_out_item;

    // Classified command handed from the front to the back
    typedef struct packed {
        t_in_item             item;
        logic [IDX_MAX_W-1:0] row;
        logic [IDX_MAX_W-1:0] col;
        logic                 last;
    } t_cmd;

    // Saturate a wide signed value to 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [67:0] x);
        logic signed [31:0] r;
        if (x > 68'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (x < -68'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = x[31:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[rtl/visibility_gain_apply.sv]
// Top level of the visibility gain apply block: front, queue, back, gain RAM.
// Depends on vga_pkg, vga_front, vga_queue, vga_back and vga_ram.
//
// Usage: items enter on the input channel (i_in_valid, o_in_stall,
// i_in_item). A load item stores an element gain and its weight factor and
// gives no result. A product item gives the next upper-triangle product, a
// frame gain item gives the incoming gain times the stored element gain.
// Results leave on o_out_valid / i_out_stall / o_out_item.
// i_cfg_we with i_cfg_data writes the element count and restarts the walk.
// Sequencing: a product or frame gain item runs through the back-end
// sequencer steps (pop, RAM read, gain product, three multiply steps, push);
// a load runs blend, magnitude, the bit-serial 43-step divider for 1/|g|^2
// and the RAM write, skipping the divider when the element is flagged or the
// gain is zero. The sequencer pops a command only when idle. A two-entry
// queue lets the front accept while the back works and while a finished
// result waits; a stalled receiver holds the output register and, once the
// queue fills, stalls the input.
// Reset clears the walk, the count (2048), the queue and output valid; the
// gain store stays undefined until loaded.
`default_nettype none

module visibility_gain_apply import vga_pkg::*; #(
    parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    input  wire t_in_item         i_in_item,
    output logic                  o_out_valid,
    input  wire logic             i_out_stall,
    output t_out_item             o_out_item,
    input  wire logic             i_cfg_we,
    input  wire logic [CFG_W-1:0] i_cfg_data
);

    localparam int IDX_W = $clog2(MAX_ELEMENTS);

    logic             q_push, q_full, q_pop, q_empty;
    t_cmd             q_in, q_out;
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr, ram_raddr_a, ram_raddr_b;
    logic [RAM_W-1:0] ram_wdata, ram_rdata_a, ram_rdata_b;

    // Accept and classify
    vga_front #(.MAX_ELEMENTS(MAX_ELEMENTS)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_item  (i_in_item),
        .o_in_stall (o_in_stall),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_q_full   (q_full),
        .o_q_push   (q_push),
        .o_q_cmd    (q_in)
    );

    // Decouple front and back
    vga_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_cmd   (q_out)
    );

    // Carry out commands
    vga_back #(.MAX_ELEMENTS(MAX_ELEMENTS)) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_empty     (q_empty),
        .i_q_cmd       (q_out),
        .o_q_pop       (q_pop),
        .o_ram_we      (ram_we),
        .o_ram_waddr   (ram_waddr),
        .o_ram_wdata   (ram_wdata),
        .o_ram_raddr_a (ram_raddr_a),
        .o_ram_raddr_b (ram_raddr_b),
        .i_ram_rdata_a (ram_rdata_a),
        .i_ram_rdata_b (ram_rdata_b),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_item    (o_out_item)
    );

    // Gain and weight factor store
    vga_ram #(.WIDTH(RAM_W), .DEPTH(MAX_ELEMENTS)) u_ram (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_waddr   (ram_waddr),
        .i_wdata   (ram_wdata),
        .i_raddr_a (ram_raddr_a),
        .i_raddr_b (ram_raddr_b),
        .o_rdata_a (ram_rdata_a),
        .o_rdata_b (ram_rdata_b)
    );

endmodule

`default_nettype wire

[rtl/vga_ram.sv]
// Generic RAM: one write port, two read ports with registered read data.
// No package dependency.
`default_nettype none

module vga_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 2048
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic      [WIDTH-1:0]         o_rdata_a,
    output logic      [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write, then register both reads
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

`default_nettype wire

[rtl/vga_front.sv]
// Front end: accepts items, holds the element count and the triangle walk,
// and turns items into commands. Depends on vga_pkg.
`default_nettype none

module vga_front import vga_pkg::*; #(
    parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    input  wire t_in_item         i_in_item,
    output logic                  o_in_stall,
    input  wire logic             i_cfg_we,
    input  wire logic [CFG_W-1:0] i_cfg_data,
    input  wire logic             i_q_full,
    output logic                  o_q_push,
    output t_cmd                  o_q_cmd
);

    localparam int IDX_W = $clog2(MAX_ELEMENTS);
    localparam int CMP_W = (CFG_W > IDX_W + 1) ? CFG_W : IDX_W + 1;
    localparam logic [CMP_W-1:0] N_MAX = CMP_W'(MAX_ELEMENTS);
    localparam logic [CMP_W-1:0] N_MIN = CMP_W'(2);

    logic [CFG_W-1:0] r_elems;
    logic [IDX_W-1:0] r_row;
    logic [IDX_W-1:0] r_col;

    logic [CMP_W-1:0] n, i, j, i1, j1, n_row, n_col;
    logic             accept, last, load_ok;
    t_req             req;

    // Clamp the element count
    always_comb begin
        n = CMP_W'(r_elems);
        if (n < N_MIN) begin
            n = N_MIN;
        end else if (n > N_MAX) begin
            n = N_MAX;
        end
    end

    // Current triangle position and the next one
    always_comb begin
        i = CMP_W'(r_row);
        j = CMP_W'(r_col);
        if (i >= n || j >= n || j < i) begin
            i = '0;
            j = '0;
        end
        last  = (i == n - 1'b1) && (j == n - 1'b1);
        i1    = i;
        j1    = j + 1'b1;
        if (j1 >= n) begin
            i1 = i + 1'b1;
            j1 = i1;
            if (i1 >= n) begin
                i1 = '0;
                j1 = '0;
            end
        end
        n_row = i1;
        n_col = j1;
    end

    // Classify the item
    assign req        = t_req'(i_in_item.req_type);
    assign accept     = i_in_valid && !i_q_full;
    assign o_in_stall = i_q_full;
    assign load_ok    = 32'(i_in_item.element) < MAX_ELEMENTS;

    always_comb begin
        o_q_push = 1'b0;
        unique case (req)
            REQ_LOAD:    o_q_push = accept && load_ok;
            REQ_PRODUCT: o_q_push = accept;
            REQ_FRAME:   o_q_push = accept;
            default:     o_q_push = 1'b0;
        endcase
    end

    always_comb begin
        o_q_cmd      = '0;
        o_q_cmd.item = i_in_item;
        if (req == REQ_PRODUCT) begin
            o_q_cmd.row  = IDX_MAX_W'(i);
            o_q_cmd.col  = IDX_MAX_W'(j);
            o_q_cmd.last = last;
        end else begin
            o_q_cmd.row  = IDX_MAX_W'(i_in_item.element);
        end
    end

    // Hold the count; advance the walk on each product
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_elems <= ELEMS_RESET;
            r_row   <= '0;
            r_col   <= '0;
        end else if (i_cfg_we) begin
            r_elems <= i_cfg_data;
            r_row   <= '0;
            r_col   <= '0;
        end else if (accept && req == REQ_PRODUCT) begin
            r_row <= IDX_W'(n_row);
            r_col <= IDX_W'(n_col);
        end
    end

endmodule

`default_nettype wire

[rtl/vga_queue.sv]
// Short command queue between front and back.
// Depends on vga_pkg for the command type and depth.
`default_nettype none

module vga_queue import vga_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_cmd,
    output logic      o_full,
    input  wire logic i_pop,
    output logic      o_empty,
    output t_cmd      o_cmd
);

    localparam int PTR_W = $clog2(Q_DEPTH);
    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    t_cmd             r_ent [Q_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_cnt;

    assign o_full  = r_cnt == CNT_W'(Q_DEPTH);
    assign o_empty = r_cnt == '0;
    assign o_cmd   = r_ent[r_rd_ptr];

    // Store entries
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_ent[r_wr_ptr] <= i_cmd;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (32'(r_wr_ptr) == Q_DEPTH - 1) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (32'(r_rd_ptr) == Q_DEPTH - 1) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

[rtl/vga_back.sv]
// Back end: sequencer that loads gains (blend, magnitude, bit-serial divide)
// and scales products and frame gains. Depends on vga_pkg and the gain RAM.
`default_nettype none

module vga_back import vga_pkg::*; #(
    parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_q_empty,
    input  wire t_cmd                            i_q_cmd,
    output logic                                 o_q_pop,
    output logic                                 o_ram_we,
    output logic [$clog2(MAX_ELEMENTS)-1:0]      o_ram_waddr,
    output logic [RAM_W-1:0]                     o_ram_wdata,
    output logic [$clog2(MAX_ELEMENTS)-1:0]      o_ram_raddr_a,
    output logic [$clog2(MAX_ELEMENTS)-1:0]      o_ram_raddr_b,
    input  wire logic [RAM_W-1:0]                i_ram_rdata_a,
    input  wire logic [RAM_W-1:0]                i_ram_rdata_b,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output t_out_item                            o_out_item
);

    localparam int IDX_W   = $clog2(MAX_ELEMENTS);
    localparam int DIV_N   = 43;
    localparam int DCNT_W  = $clog2(DIV_N);

    typedef enum logic [3:0] {
        S_IDLE, S_BLEND, S_MAG, S_DIV, S_WR,
        S_RD, S_P, S_M1, S_M2, S_M3, S_PUSH
    } t_state;

    t_state              r_state;
    t_cmd                r_cmd;
    logic signed [15:0]  r_gr, r_gi;
    logic                r_flag;
    logic [31:0]         r_m;
    logic [DIV_N-1:0]    r_num, r_q;
    logic [32:0]         r_rem;
    logic [DCNT_W-1:0]   r_cnt;
    logic signed [33:0]  r_pr, r_pi;
    logic [63:0]         r_wp, r_wlo;
    logic [31:0]         r_fj;
    logic signed [65:0]  r_p0, r_p1, r_p2, r_p3;
    logic [47:0]         r_t, r_whi;
    logic signed [31:0]  r_res_re, r_res_im;
    t_out_item           r_out;
    logic                r_out_valid;

    logic                is_frame, frame_ok, out_free;
    logic signed [17:0]  bc, bcc;
    logic signed [35:0]  bl_re, bl_im;
    logic signed [32:0]  msum;
    logic [DIV_N-1:0]    num0;
    logic [32:0]         rem_sh;
    logic                q_bit;
    logic signed [15:0]  ga_re, ga_im, gb_re, gb_im;
    logic signed [33:0]  pr_c, pi_c;
    logic [63:0]         wsum;
    logic signed [67:0]  sx, sy, rx, ry;
    logic [80:0]         wfull;
    logic [31:0]         wout, fq;

    assign is_frame = t_req'(r_cmd.item.req_type) == REQ_FRAME;
    assign frame_ok = 32'(r_cmd.row) < MAX_ELEMENTS;
    assign out_free = !r_out_valid || !i_out_stall;
    assign o_q_pop  = (r_state == S_IDLE) && !i_q_empty;

    // Blend of old and new gains, Q0.16 coefficient
    always_comb begin
        bc    = $signed({2'b00, r_cmd.item.blend_coef});
        bcc   = 18'sd65536 - bc;
        bl_re = bc * r_cmd.item.new_gain_re + bcc * r_cmd.item.old_gain_re + 36'sd32768;
        bl_im = bc * r_cmd.item.new_gain_im + bcc * r_cmd.item.old_gain_im + 36'sd32768;
    end

    // Magnitude and the rounded dividend 2^42 + m/2
    assign msum = r_gr * r_gr + r_gi * r_gi;
    assign num0 = 43'h400_0000_0000 + {12'b0, msum[31:1]};

    // One restoring divide step
    always_comb begin
        rem_sh = {r_rem[31:0], r_num[DIV_N-1]};
        q_bit  = rem_sh >= {1'b0, r_m};
    end
    assign fq = (|r_q[DIV_N-1:32]) ? 32'hFFFF_FFFF : r_q[31:0];

    // Gain pair product, or the stored gain (unity if out of range) for frame items
    always_comb begin
        ga_re = i_ram_rdata_a[63:48];
        ga_im = i_ram_rdata_a[47:32];
        gb_re = i_ram_rdata_b[63:48];
        gb_im = i_ram_rdata_b[47:32];
        if (is_frame) begin
            pr_c = frame_ok ? 34'(ga_re) : 34'(GAIN_ONE);
            pi_c = frame_ok ? 34'(ga_im) : 34'sd0;
        end else begin
            pr_c = ga_re * gb_re + ga_im * gb_im;
            pi_c = ga_im * gb_re - ga_re * gb_im;
        end
    end

    // Rounding and weight assembly
    always_comb begin
        wsum = r_wp + 64'd32768;
        sx   = r_p0 - r_p1;
        sy   = r_p2 + r_p3;
        if (is_frame) begin
            rx = (sx + 68'sd4096) >>> 13;
            ry = (sy + 68'sd4096) >>> 13;
        end else begin
            rx = (sx + 68'sd33554432) >>> 26;
            ry = (sy + 68'sd33554432) >>> 26;
        end
        wfull = {1'b0, r_whi, 32'b0} + {17'b0, r_wlo} + 81'd32768;
        wout  = (|wfull[80:48]) ? 32'hFFFF_FFFF : wfull[47:16];
    end

    // RAM ports
    assign o_ram_we      = r_state == S_WR;
    assign o_ram_waddr   = IDX_W'(r_cmd.row);
    assign o_ram_wdata   = {r_gr, r_gi, fq};
    assign o_ram_raddr_a = IDX_W'(r_cmd.row);
    assign o_ram_raddr_b = IDX_W'(r_cmd.col);

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            // Raise valid on a new result, drop it once taken
            if (r_state == S_PUSH && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (!i_q_empty) begin
                        r_cmd   <= i_q_cmd;
                        r_state <= (t_req'(i_q_cmd.item.req_type) == REQ_LOAD) ? S_BLEND : S_RD;
                    end
                end
                S_BLEND: begin
                    r_gr    <= r_cmd.item.blend_on ? bl_re[31:16] : r_cmd.item.new_gain_re;
                    r_gi    <= r_cmd.item.blend_on ? bl_im[31:16] : r_cmd.item.new_gain_im;
                    r_flag  <= r_cmd.item.gain_wt == '0;
                    r_state <= S_MAG;
                end
                S_MAG: begin
                    r_q <= '0;
                    if (r_flag || (r_gr == '0 && r_gi == '0)) begin
                        r_gr    <= GAIN_ONE;
                        r_gi    <= '0;
                        r_state <= S_WR;
                    end else begin
                        r_m     <= msum[31:0];
                        r_num   <= num0;
                        r_rem   <= '0;
                        r_cnt   <= '0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_rem <= q_bit ? rem_sh - {1'b0, r_m} : rem_sh;
                    r_q   <= {r_q[DIV_N-2:0], q_bit};
                    r_num <= {r_num[DIV_N-2:0], 1'b0};
                    r_cnt <= r_cnt + 1'b1;
                    if (32'(r_cnt) == DIV_N - 1) begin
                        r_state <= S_WR;
                    end
                end
                S_WR: begin
                    r_state <= S_IDLE;
                end
                S_RD: begin
                    r_state <= S_P;
                end
                S_P: begin
                    r_pr    <= pr_c;
                    r_pi    <= pi_c;
                    r_wp    <= r_cmd.item.vis_weight * i_ram_rdata_a[31:0];
                    r_fj    <= i_ram_rdata_b[31:0];
                    r_state <= S_M1;
                end
                S_M1: begin
                    r_p0    <= r_cmd.item.vis_re * r_pr;
                    r_p1    <= r_cmd.item.vis_im * r_pi;
                    r_t     <= wsum[63:16];
                    r_state <= S_M2;
                end
                S_M2: begin
                    r_p2    <= r_cmd.item.vis_re * r_pi;
                    r_p3    <= r_cmd.item.vis_im * r_pr;
                    r_wlo   <= r_t[31:0] * r_fj;
                    r_state <= S_M3;
                end
                S_M3: begin
                    r_whi    <= r_t[47:32] * r_fj;
                    r_res_re <= sat32(rx);
                    r_res_im <= sat32(ry);
                    r_state  <= S_PUSH;
                end
                // Load the output register only once it is free
                S_PUSH: begin
                    if (out_free) begin
                        r_out.out_re    <= r_res_re;
                        r_out.out_im    <= r_res_im;
                        r_out.scaled_wt <= is_frame ? 32'd0 : wout;
                        r_out.row       <= ELEM_W'(r_cmd.row);
                        r_out.col       <= ELEM_W'(r_cmd.col);
                        r_out.last      <= r_cmd.last;
                        r_state         <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

[rtl/vga_checker.sv]
// Port-level checker for visibility_gain_apply, attached by bind.
// Depends on vga_pkg.
`default_nettype none

module vga_checker import vga_pkg::*; (
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      o_out_valid,
    input wire logic      i_out_stall,
    input wire t_out_item o_out_item
);

    // Reset drops any pending result
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // Stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("stalled result changed");

    // Final product sits on the diagonal
    a_last_diag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.last |-> o_out_item.row == o_out_item.col)
        else $error("last flag off the diagonal");

    // Products stay in the upper triangle; frame entries carry column zero
    a_upper: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.col >= o_out_item.row) || (o_out_item.col == '0))
        else $error("product below the diagonal");

endmodule

bind visibility_gain_apply vga_checker u_vga_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);

`default_nettype wire
